>>> rtl/mbdlp_pkg.sv
// Shared types and constants for the multi-button debouncer with long-press detection.
package mbdlp_pkg;

    // Event code width and encoding
    localparam int EVENT_W = 3;
    typedef logic [EVENT_W-1:0] t_event;
    localparam t_event EVENT_NONE = '0;

    // Time and configuration widths
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [CFG_W-1:0]  t_cfg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_DEBOUNCE_MS   = 1'd0;
    localparam t_cfg_idx REG_LONG_PRESS_MS = 1'd1;

    // Configuration reset values
    localparam t_cfg DEBOUNCE_RESET   = 16'd30;
    localparam t_cfg LONG_PRESS_RESET = 16'd800;

    // Status a debounce cell reports for the current item
    typedef struct packed {
        logic update;   // stable level changed this item
        logic press;    // stable level changed to pressed
    } t_cell_stat;

endpackage

>>> rtl/mbdlp_cell.sv
// One debounce cell: tracks raw and stable level of a single button.
module mbdlp_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  mbdlp_pkg::t_time    i_now_ms,
    input  logic                i_raw,
    input  mbdlp_pkg::t_cfg     i_debounce_ms,
    input  logic                i_blocked,
    output logic                o_blocked,
    output mbdlp_pkg::t_cell_stat o_stat
);

    logic             r_last;
    logic             r_steady;
    mbdlp_pkg::t_time r_change;
    logic             n_last;
    logic             n_steady;
    mbdlp_pkg::t_time n_change;

    logic             active;
    logic             changed;
    mbdlp_pkg::t_time ref_time;
    mbdlp_pkg::t_time elapsed;
    logic             settled;

    // A cell only samples when no earlier cell reported a press this item
    assign active   = i_en && !i_blocked;
    assign changed  = (i_raw != r_last);
    assign ref_time = changed ? i_now_ms : r_change;
    assign elapsed  = i_now_ms - ref_time;
    assign settled  = (elapsed >= mbdlp_pkg::TIME_W'(i_debounce_ms));

    always_comb begin
        n_last   = r_last;
        n_steady = r_steady;
        n_change = r_change;
        o_stat   = '0;
        if (active) begin
            n_last   = i_raw;
            n_change = ref_time;
            if (settled && (i_raw != r_steady)) begin
                n_steady      = i_raw;
                o_stat.update = 1'b1;
                o_stat.press  = !i_raw;
            end
        end
    end

    // Pass the block on down the row
    assign o_blocked = i_blocked || o_stat.press;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b1;
            r_steady <= 1'b1;
            r_change <= '0;
        end else begin
            r_last   <= n_last;
            r_steady <= n_steady;
            r_change <= n_change;
        end
    end

endmodule

>>> rtl/mbdlp_hold.sv
// Long-press timer for the centre key.
module mbdlp_hold (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  mbdlp_pkg::t_time      i_now_ms,
    input  mbdlp_pkg::t_cfg       i_long_press_ms,
    input  mbdlp_pkg::t_cell_stat i_centre,
    input  logic                  i_any_press,
    output logic                  o_long
);

    mbdlp_pkg::t_time r_hold;
    logic             r_reported;
    mbdlp_pkg::t_time n_hold;
    logic             n_reported;

    mbdlp_pkg::t_time held;

    assign held = i_now_ms - r_hold;

    // Long press only when no press this item and the centre key stayed down;
    // a hold time of zero means idle
    assign o_long = i_en && !i_any_press && !i_centre.update && !r_reported
                    && (r_hold != '0)
                    && (held >= mbdlp_pkg::TIME_W'(i_long_press_ms));

    always_comb begin
        n_hold     = r_hold;
        n_reported = r_reported;
        if (i_centre.update) begin
            n_hold     = i_centre.press ? i_now_ms : '0;
            n_reported = 1'b0;
        end else if (o_long) begin
            n_reported = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold     <= '0;
            r_reported <= 1'b0;
        end else begin
            r_hold     <= n_hold;
            r_reported <= n_reported;
        end
    end

endmodule

>>> rtl/multi_button_debounce_long_press_top.sv
// Top level: row of debounce cells, centre-key long-press timer and output buffer.
//
// Debounces NUM_BUTTONS active-low buttons (1 = released) from poll items that carry a
// millisecond timestamp and the raw levels, and returns one event code per item:
// 0 none, i+1 for a new press of button i (lowest index wins, later buttons are not
// sampled in that poll), NUM_BUTTONS+1 (masked to 3 bits) for a long press of the
// last button, the centre key. The whole row of cells, each a 32-bit subtract and
// compare, settles in the accept cycle and the result is registered, so items may be
// accepted on every cycle while o_in_ready is high. A two-entry output buffer keeps
// o_in_ready high while one result waits on i_out_ready. Configuration:
// index 0 is debounce_ms (reset 30), index 1 is long_press_ms (reset 800); o_cfg_ready
// is always high, and writes are expected only while the block is idle.
module multi_button_debounce_long_press_top #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Poll item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mbdlp_pkg::t_time              i_now_ms,
    input  logic [NUM_BUTTONS-1:0]        i_raw_levels,
    // Event channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mbdlp_pkg::t_event             o_event_code,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  mbdlp_pkg::t_cfg_idx           i_cfg_index,
    input  mbdlp_pkg::t_cfg               i_cfg_data
);

    localparam mbdlp_pkg::t_event LONG_CODE = mbdlp_pkg::t_event'(NUM_BUTTONS + 1);

    // Configuration registers
    mbdlp_pkg::t_cfg r_debounce_ms;
    mbdlp_pkg::t_cfg r_long_press_ms;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= mbdlp_pkg::DEBOUNCE_RESET;
            r_long_press_ms <= mbdlp_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mbdlp_pkg::REG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data;
                mbdlp_pkg::REG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic accept;
    assign accept = i_in_valid && o_in_ready;

    // Row of debounce cells; a press blocks the cells after it
    logic [NUM_BUTTONS:0]  blocked;
    mbdlp_pkg::t_cell_stat stat [NUM_BUTTONS];

    assign blocked[0] = 1'b0;

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_cell
        mbdlp_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (accept),
            .i_now_ms      (i_now_ms),
            .i_raw         (i_raw_levels[g]),
            .i_debounce_ms (r_debounce_ms),
            .i_blocked     (blocked[g]),
            .o_blocked     (blocked[g+1]),
            .o_stat        (stat[g])
        );
    end

    // Centre key timer
    logic long_evt;

    mbdlp_hold u_hold (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (accept),
        .i_now_ms        (i_now_ms),
        .i_long_press_ms (r_long_press_ms),
        .i_centre        (stat[NUM_BUTTONS-1]),
        .i_any_press     (blocked[NUM_BUTTONS]),
        .o_long          (long_evt)
    );

    // Event code: at most one cell presses per item
    mbdlp_pkg::t_event code;

    always_comb begin
        code = mbdlp_pkg::EVENT_NONE;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (stat[i].press) begin
                code = mbdlp_pkg::t_event'(i + 1);
            end
        end
        if (long_evt) begin
            code = LONG_CODE;
        end
    end

    // Output register with skid entry
    logic              r_out_valid;
    mbdlp_pkg::t_event r_out_code;
    logic              r_skid_valid;
    mbdlp_pkg::t_event r_skid_code;
    logic              n_out_valid;
    mbdlp_pkg::t_event n_out_code;
    logic              n_skid_valid;
    mbdlp_pkg::t_event n_skid_code;

    logic take;
    assign take = r_out_valid && i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_code   = r_out_code;
        n_skid_valid = r_skid_valid;
        n_skid_code  = r_skid_code;
        if (r_out_valid && !take) begin
            if (accept) begin
                n_skid_valid = 1'b1;
                n_skid_code  = code;
            end
        end else if (r_skid_valid) begin
            n_out_valid  = 1'b1;
            n_out_code   = r_skid_code;
            n_skid_valid = accept;
            n_skid_code  = code;
        end else begin
            n_out_valid = accept;
            n_out_code  = code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_code  <= n_out_code;
        r_skid_code <= n_skid_code;
    end

    assign o_in_ready   = !r_skid_valid;
    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_out_code;

endmodule
